// ===== hdl/mdps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdps_pkg
// Shared types and constants of the multiplexed digit PWM scanner.
// ----------------------------------------------------------------------------
package mdps_pkg;

	localparam int DEFAULT_MAX_DIGITS = 8;

	// item opcodes
	localparam logic [1:0] OP_TICK         = 2'd0;
	localparam logic [1:0] OP_WRITE_PATTERN = 2'd1;
	localparam logic [1:0] OP_WRITE_BRIGHT  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_DIGIT_COUNT    = 2'd0;
	localparam logic [1:0] REG_SUBFIELD_COUNT = 2'd1;
	localparam logic [1:0] REG_BRIGHT_ENABLE  = 2'd2;
	localparam logic [1:0] REG_ASLEEP         = 2'd3;

	// output commands
	localparam logic CMD_DRAW    = 1'b0;
	localparam logic CMD_DISABLE = 1'b1;

	// reset values
	localparam logic [3:0] DIGIT_COUNT_RESET    = 4'd4;
	localparam logic [7:0] SUBFIELD_COUNT_RESET = 8'd1;
	localparam logic [3:0] PREV_DIGIT_RESET     = 4'hF;
	localparam logic [7:0] PATTERN_RESET        = 8'h00;
	localparam logic [7:0] BRIGHT_FULL          = 8'hFF;

	typedef struct packed {
		logic [7:0] pattern;
		logic [7:0] brightness;
	} store_rd_t;

endpackage
`default_nettype wire

// ===== hdl/multiplexed_digit_pwm_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multiplexed_digit_pwm_scanner
// Scans a multiplexed segment display with per-digit subfield brightness.
// ----------------------------------------------------------------------------
// A tick's command passes stage 1, then the output register. Throughput:
// one item per cycle unless the output stalls; set by the single read of
// the digit memories per tick and the one multiply and compare in the draw
// stage. Reset: asynchronous; stores read as reset contents right away
// through valid bits, so no clearing pass is needed.
module multiplexed_digit_pwm_scanner #(
	parameter int MAX_DIGITS = mdps_pkg::DEFAULT_MAX_DIGITS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write_enable,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [2:0] digit_index,
	input  wire logic [7:0] write_value,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            command,
	output logic [2:0]      digit_number,
	output logic [7:0]      segment_bits
);

	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	// configuration
	logic [3:0] digit_count_q;
	logic [7:0] subfield_count_q;
	logic       bright_enable_q;
	logic       asleep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q    <= mdps_pkg::DIGIT_COUNT_RESET;
			subfield_count_q <= mdps_pkg::SUBFIELD_COUNT_RESET;
			bright_enable_q  <= 1'b0;
			asleep_q         <= 1'b0;
		end else if (cfg_write_enable) begin
			case (cfg_index)
				mdps_pkg::REG_DIGIT_COUNT:    digit_count_q    <= cfg_data[3:0];
				mdps_pkg::REG_SUBFIELD_COUNT: subfield_count_q <= cfg_data;
				mdps_pkg::REG_BRIGHT_ENABLE:  bright_enable_q  <= cfg_data[0];
				mdps_pkg::REG_ASLEEP:         asleep_q         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake and item decode
	logic in_fire;
	logic tick_go;
	logic wr_go;
	logic wr_bright;
	logic s1_valid;
	logic s1_move;
	logic out_valid_q;

	assign s1_move  = !out_valid_q || out_ready;
	assign in_ready = !s1_valid || s1_move;
	assign in_fire  = in_valid && in_ready;
	assign tick_go  = in_fire && (opcode == mdps_pkg::OP_TICK) && !asleep_q;
	assign wr_bright = (opcode == mdps_pkg::OP_WRITE_BRIGHT);
	assign wr_go    = in_fire && (5'(digit_index) < 5'(MAX_DIGITS))
		&& ((opcode == mdps_pkg::OP_WRITE_PATTERN) || wr_bright);

	// scan position, advanced as each tick is accepted while awake
	logic [AW-1:0] cur_digit_q;
	logic [3:0]    prev_digit_q;
	logic [7:0]    cur_sub_q;
	logic          plain_mode;
	logic [4:0]    scan_limit;
	logic [4:0]    digit_inc;
	logic [AW-1:0] digit_next;
	logic [7:0]    sub_inc;
	logic          sub_wrap;
	logic          digit_changed;

	assign plain_mode    = (subfield_count_q == 8'd1);
	assign scan_limit    = (5'(digit_count_q) > 5'(MAX_DIGITS)) ? 5'(MAX_DIGITS)
		: 5'(digit_count_q);
	assign digit_inc     = 5'(cur_digit_q) + 5'd1;
	assign digit_next    = (digit_inc >= scan_limit) ? '0 : AW'(digit_inc);
	assign sub_inc       = cur_sub_q + 8'd1;
	assign sub_wrap      = (sub_inc >= subfield_count_q);
	assign digit_changed = (4'(cur_digit_q) != prev_digit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_digit_q  <= '0;
			prev_digit_q <= mdps_pkg::PREV_DIGIT_RESET;
			cur_sub_q    <= '0;
		end else if (tick_go) begin
			prev_digit_q <= 4'(cur_digit_q);
			if (plain_mode) begin
				cur_digit_q <= digit_next;
			end else if (sub_wrap) begin
				cur_digit_q <= digit_next;
				cur_sub_q   <= '0;
			end else begin
				cur_sub_q <= sub_inc;
			end
		end
	end

	// digit memories
	mdps_pkg::store_rd_t rd_data;

	mdps_store #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_go),
		.wr_bright(wr_bright),
		.wr_addr  (AW'(digit_index)),
		.wr_data  (write_value),
		.rd_en    (tick_go),
		.rd_addr  (cur_digit_q),
		.rd_data  (rd_data)
	);

	// stage 1: tick waiting for its memory data
	logic [2:0] digit_s1;
	logic [7:0] sub_s1;
	logic       changed_s1;
	logic       plain_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= tick_go;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			digit_s1   <= 3'(cur_digit_q);
			sub_s1     <= cur_sub_q;
			changed_s1 <= digit_changed;
			plain_s1   <= plain_mode;
		end
	end

	// draw decision
	logic [7:0]  bright;
	logic [15:0] on_product;
	logic [7:0]  on_limit;
	logic [7:0]  mod_pattern;
	logic        mod_emit;
	logic        res_emit;
	logic        res_cmd;
	logic [7:0]  res_bits;
	logic [7:0]  on_limit_q;
	logic [7:0]  last_drawn_q;

	assign bright      = bright_enable_q ? rd_data.brightness : mdps_pkg::BRIGHT_FULL;
	assign on_product  = 16'(subfield_count_q) * 16'(bright);
	assign on_limit    = changed_s1 ? on_product[15:8] : on_limit_q;
	assign mod_pattern = ((bright == mdps_pkg::BRIGHT_FULL) || (sub_s1 < on_limit))
		? rd_data.pattern : 8'h00;
	assign mod_emit    = (mod_pattern != last_drawn_q) || changed_s1;

	always_comb begin
		if (plain_s1) begin
			res_emit = 1'b1;
			res_cmd  = (bright == 8'd0) ? mdps_pkg::CMD_DISABLE : mdps_pkg::CMD_DRAW;
			res_bits = (bright == 8'd0) ? 8'h00 : rd_data.pattern;
		end else begin
			res_emit = mod_emit;
			res_cmd  = mdps_pkg::CMD_DRAW;
			res_bits = mod_pattern;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_limit_q   <= '0;
			last_drawn_q <= '0;
			out_valid_q  <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= s1_valid && res_emit;
			if (s1_valid && !plain_s1) begin
				on_limit_q <= on_limit;
				if (mod_emit) begin
					last_drawn_q <= mod_pattern;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (s1_move && s1_valid && res_emit) begin
			command      <= res_cmd;
			digit_number <= digit_s1;
			segment_bits <= res_bits;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== hdl/mdps_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdps_store
// Per-digit pattern and brightness memories, one write and one read per
// cycle, read data registered. Valid bits give the reset contents.
// ----------------------------------------------------------------------------
module mdps_store #(
	parameter int MAX_DIGITS = mdps_pkg::DEFAULT_MAX_DIGITS,
	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic                  wr_bright,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic [7:0]            wr_data,
	input  wire logic                  rd_en,
	input  wire logic [AW-1:0]         rd_addr,
	output mdps_pkg::store_rd_t        rd_data
);

	logic [7:0]            pattern_mem [MAX_DIGITS];
	logic [7:0]            bright_mem  [MAX_DIGITS];
	logic [MAX_DIGITS-1:0] pat_vld_q;
	logic [MAX_DIGITS-1:0] bri_vld_q;
	logic [7:0]            pat_rd_q;
	logic [7:0]            bri_rd_q;
	logic                  pat_rd_vld_q;
	logic                  bri_rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en && !wr_bright) begin
			pattern_mem[wr_addr] <= wr_data;
		end
		if (wr_en && wr_bright) begin
			bright_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			pat_rd_q <= pattern_mem[rd_addr];
			bri_rd_q <= bright_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_vld_q    <= '0;
			bri_vld_q    <= '0;
			pat_rd_vld_q <= 1'b0;
			bri_rd_vld_q <= 1'b0;
		end else begin
			if (wr_en && !wr_bright) begin
				pat_vld_q[wr_addr] <= 1'b1;
			end
			if (wr_en && wr_bright) begin
				bri_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				pat_rd_vld_q <= pat_vld_q[rd_addr];
				bri_rd_vld_q <= bri_vld_q[rd_addr];
			end
		end
	end

	// never-written entries read as their reset contents
	assign rd_data.pattern    = pat_rd_vld_q ? pat_rd_q : mdps_pkg::PATTERN_RESET;
	assign rd_data.brightness = bri_rd_vld_q ? bri_rd_q : mdps_pkg::BRIGHT_FULL;

endmodule
`default_nettype wire

// ===== verif/multiplexed_digit_pwm_scanner_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_digit_pwm_scanner_test
// Drives pattern writes, brightness writes and refresh ticks into the scanner
// under random idle gaps and output stalls. Checks every draw or disable
// command against a cycle-free scan predictor across several register setups.
// ----------------------------------------------------------------------------
module multiplexed_digit_pwm_scanner_test;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] digit;
		logic [7:0] value;
	} scan_item_t;

	typedef struct packed {
		logic       cmd;
		logic [2:0] digit;
		logic [7:0] segs;
	} scan_cmd_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write_enable = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [7:0] cfg_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] opcode = mdps_pkg::OP_TICK;
	logic [2:0] digit_index = 3'd0;
	logic [7:0] write_value = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       command;
	logic [2:0] digit_number;
	logic [7:0] segment_bits;

	multiplexed_digit_pwm_scanner uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.digit_index      (digit_index),
		.write_value      (write_value),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.command          (command),
		.digit_number     (digit_number),
		.segment_bits     (segment_bits)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// scanner state as the block should hold it
	logic [7:0] segment_mem [mdps_pkg::DEFAULT_MAX_DIGITS];
	logic [7:0] level_mem [mdps_pkg::DEFAULT_MAX_DIGITS];
	logic [2:0] scan_digit;
	logic [3:0] last_digit;
	logic [7:0] subfield;
	logic [7:0] lit_subfields;
	logic [7:0] last_shown;
	logic [3:0] digits_cfg;
	logic [7:0] subfields_cfg;
	logic       bright_en_cfg;
	logic       asleep_cfg;

	scan_item_t scan_items [$];
	scan_cmd_t  display_cmds_due [$];
	scan_item_t next_item;
	int unsigned send_wait = 0;
	int unsigned hold_wait = 0;
	int unsigned mismatches = 0;
	bit         calm = 1'b0;

	function automatic int unsigned draw_wait();
		if ($urandom_range(0, 40) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic void step_digit();
		int span;
		int nxt;
		span = (digits_cfg > mdps_pkg::DEFAULT_MAX_DIGITS) ? mdps_pkg::DEFAULT_MAX_DIGITS
			: int'(digits_cfg);
		nxt = int'(scan_digit) + 1;
		scan_digit = (nxt >= span) ? 3'd0 : 3'(nxt);
	endfunction

	function automatic void advance_scanner(logic [1:0] op, logic [2:0] idx, logic [7:0] val);
		logic [7:0] level;
		logic [7:0] shown;
		logic       new_digit;
		scan_cmd_t  due;
		case (op)
			mdps_pkg::OP_WRITE_PATTERN: segment_mem[idx] = val;
			mdps_pkg::OP_WRITE_BRIGHT:  level_mem[idx] = val;
			mdps_pkg::OP_TICK: if (!asleep_cfg) begin
				level = bright_en_cfg ? level_mem[scan_digit] : mdps_pkg::BRIGHT_FULL;
				if (subfields_cfg == 8'd1) begin
					if (level == 8'd0)
						due = '{mdps_pkg::CMD_DISABLE, scan_digit, 8'h00};
					else
						due = '{mdps_pkg::CMD_DRAW, scan_digit, segment_mem[scan_digit]};
					display_cmds_due.push_back(due);
					last_digit = {1'b0, scan_digit};
					step_digit();
				end else begin
					new_digit = ({1'b0, scan_digit} != last_digit);
					if (new_digit)
						lit_subfields = 8'((int'(subfields_cfg) * int'(level)) / 256);
					shown = (level == mdps_pkg::BRIGHT_FULL || subfield < lit_subfields) ?
						segment_mem[scan_digit] : 8'h00;
					// redraw only on a new digit or a changed pattern
					if (shown != last_shown || new_digit) begin
						due = '{mdps_pkg::CMD_DRAW, scan_digit, shown};
						display_cmds_due.push_back(due);
						last_shown = shown;
					end
					subfield = subfield + 8'd1;
					last_digit = {1'b0, scan_digit};
					if (subfield >= subfields_cfg) begin
						step_digit();
						subfield = 8'd0;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// item driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				advance_scanner(opcode, digit_index, write_value);
				send_wait = draw_wait();
			end
			if (!in_valid || in_ready) begin
				if (send_wait == 0 && scan_items.size() != 0) begin
					next_item = scan_items.pop_front();
					in_valid <= 1'b1;
					opcode <= next_item.op;
					digit_index <= next_item.digit;
					write_value <= next_item.value;
				end else begin
					in_valid <= 1'b0;
					if (send_wait != 0)
						send_wait--;
				end
			end
		end
	end

	// command monitor
	always @(posedge clk) begin
		scan_cmd_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (display_cmds_due.size() == 0) begin
					$error("unexpected command %0d digit %0d segments %02h",
						command, digit_number, segment_bits);
					mismatches++;
				end else begin
					due = display_cmds_due.pop_front();
					if (command !== due.cmd) begin
						$error("command: expected %0d, got %0d", due.cmd, command);
						mismatches++;
					end
					if (digit_number !== due.digit) begin
						$error("digit_number: expected %0d, got %0d", due.digit, digit_number);
						mismatches++;
					end
					if (segment_bits !== due.segs) begin
						$error("segment_bits: expected %02h, got %02h", due.segs, segment_bits);
						mismatches++;
					end
				end
				hold_wait = draw_wait();
			end
			if (hold_wait != 0) begin
				out_ready <= 1'b0;
				hold_wait--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic queue_item(logic [1:0] op, logic [2:0] d, logic [7:0] v);
		scan_items.push_back('{op, d, v});
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] data);
		@(posedge clk);
		cfg_write_enable <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			mdps_pkg::REG_DIGIT_COUNT:    digits_cfg = data[3:0];
			mdps_pkg::REG_SUBFIELD_COUNT: subfields_cfg = data;
			mdps_pkg::REG_BRIGHT_ENABLE:  bright_en_cfg = data[0];
			mdps_pkg::REG_ASLEEP:         asleep_cfg = data[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write_enable <= 1'b0;
	endtask

	// wait for the block to drain, then let writes in flight retire
	task automatic settle();
		do
			@(posedge clk);
		while (scan_items.size() != 0 || in_valid || display_cmds_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			3: return 8'd254;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int unsigned phase;
		int unsigned counted;
		int unsigned n;
		int unsigned r;
		logic [3:0] dc;
		logic [7:0] sc;
		logic       be;
		logic       sl;
		logic [1:0] op;

		for (int i = 0; i < mdps_pkg::DEFAULT_MAX_DIGITS; i++) begin
			segment_mem[i] = mdps_pkg::PATTERN_RESET;
			level_mem[i] = mdps_pkg::BRIGHT_FULL;
		end
		scan_digit = 3'd0;
		last_digit = mdps_pkg::PREV_DIGIT_RESET;
		subfield = 8'd0;
		lit_subfields = 8'd0;
		last_shown = mdps_pkg::PATTERN_RESET;
		digits_cfg = mdps_pkg::DIGIT_COUNT_RESET;
		subfields_cfg = mdps_pkg::SUBFIELD_COUNT_RESET;
		bright_en_cfg = 1'b0;
		asleep_cfg = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// plain scan at reset setup; brightness ignored, unused opcode dropped
		queue_item(mdps_pkg::OP_WRITE_PATTERN, 3'd0, 8'hFF);
		queue_item(mdps_pkg::OP_WRITE_PATTERN, 3'd1, 8'h00);
		queue_item(mdps_pkg::OP_WRITE_PATTERN, 3'd2, 8'hA5);
		queue_item(mdps_pkg::OP_WRITE_PATTERN, 3'd3, 8'h5A);
		queue_item(mdps_pkg::OP_WRITE_PATTERN, 3'd7, 8'h81);
		queue_item(mdps_pkg::OP_WRITE_BRIGHT, 3'd0, 8'h00);
		queue_item(OP_UNUSED, 3'd7, 8'hFF);
		repeat (5) queue_item(mdps_pkg::OP_TICK, 3'd7, 8'hFF);
		settle();

		// zero brightness turns into a disable command
		write_reg(mdps_pkg::REG_BRIGHT_ENABLE, 8'd1);
		repeat (4) queue_item(mdps_pkg::OP_TICK, 3'd0, 8'h00);
		settle();

		// modulated scan over two digits, half brightness on digit 1
		write_reg(mdps_pkg::REG_SUBFIELD_COUNT, 8'd4);
		write_reg(mdps_pkg::REG_DIGIT_COUNT, 8'd2);
		queue_item(mdps_pkg::OP_WRITE_BRIGHT, 3'd1, 8'd128);
		queue_item(mdps_pkg::OP_WRITE_PATTERN, 3'd1, 8'h3C);
		repeat (8) queue_item(mdps_pkg::OP_TICK, 3'd5, 8'h42);
		settle();

		phase = 0;
		counted = 0;
		while (counted < 1900) begin
			case (phase)
				0: begin dc = 4'd0;  sc = 8'd0;   be = 1'b1; sl = 1'b0; end
				1: begin dc = 4'd15; sc = 8'd255; be = 1'b1; sl = 1'b0; end
				2: begin dc = 4'd8;  sc = 8'd1;   be = 1'b1; sl = 1'b1; end
				3: begin dc = 4'd1;  sc = 8'd2;   be = 1'b0; sl = 1'b0; end
				default: begin
					dc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
						4'($urandom_range(1, 8));
					r = $urandom_range(0, 9);
					if (r == 0)
						sc = 8'd0;
					else if (r == 1)
						sc = 8'd1;
					else if (r == 2)
						sc = 8'd255;
					else if (r == 3)
						sc = 8'($urandom_range(0, 255));
					else
						sc = 8'($urandom_range(2, 8));
					be = 1'($urandom_range(0, 1));
					sl = ($urandom_range(0, 7) == 0);
				end
			endcase
			write_reg(mdps_pkg::REG_DIGIT_COUNT, {4'd0, dc});
			write_reg(mdps_pkg::REG_SUBFIELD_COUNT, sc);
			write_reg(mdps_pkg::REG_BRIGHT_ENABLE, {7'd0, be});
			write_reg(mdps_pkg::REG_ASLEEP, {7'd0, sl});

			n = $urandom_range(60, 200);
			for (int k = 0; k < n; k++) begin
				r = $urandom_range(0, 19);
				if (r < 11)
					op = mdps_pkg::OP_TICK;
				else if (r < 15)
					op = mdps_pkg::OP_WRITE_PATTERN;
				else if (r < 19)
					op = mdps_pkg::OP_WRITE_BRIGHT;
				else
					op = OP_UNUSED;
				if (op == mdps_pkg::OP_WRITE_BRIGHT)
					queue_item(op, 3'($urandom_range(0, 7)), pick_level());
				else
					queue_item(op, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
				counted++;
			end
			settle();
			phase++;
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && display_cmds_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
